FILE: src/sdat_pkg.sv
// ----------------------------------------------------------------------------
// sdat_pkg
// Shared types and constants for the sorted day accumulator table.
// ----------------------------------------------------------------------------
package sdat_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int DAY_W     = 16;
    localparam int SEC_W     = 16;
    localparam int EPOCH_W   = 32;
    localparam int ADD_W     = 32;
    localparam int OUTC_W    = 3;

    localparam logic [SEC_W-1:0] SEC_MAX = 16'hFFFF;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [OUTC_W-1:0] {
        OC_UPDATED  = 3'd0,
        OC_INSERTED = 3'd1,
        OC_DROPPED  = 3'd2,
        OC_IGNORED  = 3'd3,
        OC_HIT      = 3'd4,
        OC_MISS     = 3'd5
    } t_outcome;

    typedef struct packed {
        logic [SEC_W-1:0]   day_seconds;
        t_outcome           outcome;
        logic [EPOCH_W-1:0] first_day;
    } t_result;

endpackage

FILE: src/sdat_ifs.sv
// ----------------------------------------------------------------------------
// sdat interfaces
// Valid/ready channels for items, results and the epoch base register.
// ----------------------------------------------------------------------------
interface sdat_in_if import sdat_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [EPOCH_W-1:0] epoch_day;
    logic [ADD_W-1:0]   add_seconds;

    modport source (output valid, command, epoch_day, add_seconds, input ready);
    modport sink   (input valid, command, epoch_day, add_seconds, output ready);
endinterface

interface sdat_out_if import sdat_pkg::*; #(
    parameter int CNT_W = $clog2(DEPTH_DEF + 1)
) ();
    logic               valid;
    logic               ready;
    logic [SEC_W-1:0]   day_seconds;
    logic [OUTC_W-1:0]  outcome;
    logic [CNT_W-1:0]   entry_count;
    logic [EPOCH_W-1:0] first_day;

    modport source (output valid, day_seconds, outcome, entry_count, first_day,
                    input ready);
    modport sink   (input valid, day_seconds, outcome, entry_count, first_day,
                    output ready);
endinterface

interface sdat_cfg_if import sdat_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EPOCH_W-1:0] epoch_base;

    modport source (output valid, epoch_base, input ready);
    modport sink   (input valid, epoch_base, output ready);
endinterface

FILE: src/sdat_engine.sv
// ----------------------------------------------------------------------------
// sdat_engine
// Entry RAM plus sequencer: binary search, update in place, or sorted insert
// by shifting the tail up one slot. The RAM is a ring; dropping the oldest
// entry just advances the head.
// ----------------------------------------------------------------------------
module sdat_engine import sdat_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_command,
    input  logic [EPOCH_W-1:0] i_epoch_day,
    input  logic [ADD_W-1:0]   i_add_seconds,
    input  logic [EPOCH_W-1:0] i_epoch_base,
    input  logic               i_out_free,
    output logic               o_idle,
    output logic               o_res_valid,
    output t_result            o_res,
    output logic [CW-1:0]      o_entry_count
);

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [SEC_W-1:0] sec;
    } t_entry;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SRCH_RD   = 10'b00_0000_0010,
        S_SRCH_CMP  = 10'b00_0000_0100,
        S_PROBE     = 10'b00_0000_1000,
        S_NOHIT     = 10'b00_0001_0000,
        S_SHIFT     = 10'b00_0010_0000,
        S_WRITE     = 10'b00_0100_0000,
        S_FIRST_RD  = 10'b00_1000_0000,
        S_FIRST_CMP = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } t_state;

    // ring index: logical slot -> physical address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(idx);
        if (s >= (CW+1)'(TABLE_DEPTH)) begin
            s = s - (CW+1)'(TABLE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    t_state           r_state,   n_state;
    logic             r_cmd,     n_cmd;
    logic [DAY_W-1:0] r_day,     n_day;
    logic [ADD_W-1:0] r_secs,    n_secs;
    logic [CW-1:0]    r_lo,      n_lo;
    logic [CW-1:0]    r_hi,      n_hi;
    logic [CW-1:0]    r_pos,     n_pos;
    logic [CW-1:0]    r_k,       n_k;
    logic [CW-1:0]    r_wdst,    n_wdst;
    logic             r_wvalid,  n_wvalid;
    logic [CW-1:0]    r_count,   n_count;
    logic [AW-1:0]    r_head,    n_head;
    t_outcome         r_outcome, n_outcome;
    logic [SEC_W-1:0] r_sec_res, n_sec_res;
    logic [EPOCH_W-1:0] r_first, n_first;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    t_entry           w_wdata;
    logic [AW-1:0]    w_raddr;

    logic [EPOCH_W:0] w_rel;
    logic             w_in_range;
    logic [CW:0]      w_mid_sum;
    logic [CW-1:0]    w_mid;
    logic [ADD_W:0]   w_sum;
    logic [SEC_W-1:0] w_upd_sec;
    logic [SEC_W-1:0] w_ins_sec;
    logic             w_shift_rd;

    // exact difference, one extra bit so no wrap
    assign w_rel      = {i_epoch_day[EPOCH_W-1], i_epoch_day}
                      - {i_epoch_base[EPOCH_W-1], i_epoch_base};
    assign w_in_range = (w_rel[EPOCH_W:DAY_W] == '0);

    assign w_mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_mid_sum[CW:1];

    assign w_sum      = (ADD_W+1)'(r_rd_data.sec) + {1'b0, r_secs};
    assign w_upd_sec  = (|w_sum[ADD_W:SEC_W]) ? SEC_MAX : w_sum[SEC_W-1:0];
    assign w_ins_sec  = (|r_secs[ADD_W-1:SEC_W]) ? SEC_MAX : r_secs[SEC_W-1:0];
    assign w_shift_rd = (r_k > r_pos);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_day     = r_day;
        n_secs    = r_secs;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_pos     = r_pos;
        n_k       = r_k;
        n_wdst    = r_wdst;
        n_wvalid  = 1'b0;
        n_count   = r_count;
        n_head    = r_head;
        n_outcome = r_outcome;
        n_sec_res = r_sec_res;
        n_first   = r_first;
        w_we      = 1'b0;
        w_waddr   = phys(r_head, r_pos);
        w_wdata   = '{day: r_day, sec: w_ins_sec};
        w_raddr   = phys(r_head, w_mid);
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = i_command;
                    n_day     = w_rel[DAY_W-1:0];
                    n_secs    = i_add_seconds;
                    n_lo      = '0;
                    n_hi      = r_count;
                    n_sec_res = '0;
                    if (!w_in_range) begin
                        n_outcome = (i_command == CMD_LOOKUP) ? OC_MISS : OC_IGNORED;
                        n_state   = S_FIRST_RD;
                    end else if (i_command == CMD_ADD && i_add_seconds == '0) begin
                        n_outcome = OC_IGNORED;
                        n_state   = S_FIRST_RD;
                    end else begin
                        n_state   = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    n_state = S_SRCH_CMP;
                end else if (r_lo < r_count) begin
                    // lower bound found; fetch it to test for an exact match
                    w_raddr = phys(r_head, r_lo);
                    n_state = S_PROBE;
                end else begin
                    n_state = S_NOHIT;
                end
            end
            S_SRCH_CMP: begin
                if (r_rd_data.day < r_day) begin
                    n_lo = w_mid + CW'(1);
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_SRCH_RD;
            end
            S_PROBE: begin
                if (r_rd_data.day == r_day) begin
                    if (r_cmd == CMD_LOOKUP) begin
                        n_sec_res = r_rd_data.sec;
                        n_outcome = OC_HIT;
                    end else begin
                        w_we      = 1'b1;
                        w_waddr   = phys(r_head, r_lo);
                        w_wdata   = '{day: r_day, sec: w_upd_sec};
                        n_sec_res = w_upd_sec;
                        n_outcome = OC_UPDATED;
                    end
                    n_state = S_FIRST_RD;
                end else begin
                    n_state = S_NOHIT;
                end
            end
            S_NOHIT: begin
                if (r_cmd == CMD_LOOKUP) begin
                    n_outcome = OC_MISS;
                    n_state   = S_FIRST_RD;
                end else begin
                    if (r_count == CW'(TABLE_DEPTH)) begin
                        // full: retire the oldest slot by moving the head
                        n_head    = (r_head == AW'(TABLE_DEPTH - 1)) ? '0 : r_head + AW'(1);
                        n_count   = r_count - CW'(1);
                        n_pos     = (r_lo == '0) ? '0 : r_lo - CW'(1);
                        n_k       = r_count - CW'(1);
                        n_outcome = OC_DROPPED;
                    end else begin
                        n_pos     = r_lo;
                        n_k       = r_count;
                        n_outcome = OC_INSERTED;
                    end
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // read slot k-1 while writing the slot read last cycle one up
                w_raddr = phys(r_head, r_k - CW'(1));
                if (r_wvalid) begin
                    w_we    = 1'b1;
                    w_waddr = phys(r_head, r_wdst);
                    w_wdata = r_rd_data;
                end
                if (w_shift_rd) begin
                    n_wvalid = 1'b1;
                    n_wdst   = r_k;
                    n_k      = r_k - CW'(1);
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                w_we      = 1'b1;
                w_waddr   = phys(r_head, r_pos);
                w_wdata   = '{day: r_day, sec: w_ins_sec};
                n_sec_res = w_ins_sec;
                n_count   = r_count + CW'(1);
                n_state   = S_FIRST_RD;
            end
            S_FIRST_RD: begin
                w_raddr = r_head;
                if (r_count == '0) begin
                    n_first = '1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_FIRST_CMP;
                end
            end
            S_FIRST_CMP: begin
                n_first = i_epoch_base + EPOCH_W'(r_rd_data.day);
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_wvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_wvalid <= n_wvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_day     <= n_day;
        r_secs    <= n_secs;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_pos     <= n_pos;
        r_k       <= n_k;
        r_wdst    <= n_wdst;
        r_outcome <= n_outcome;
        r_sec_res <= n_sec_res;
        r_first   <= n_first;
    end

    assign o_idle        = (r_state == S_IDLE);
    assign o_res         = '{day_seconds: r_sec_res, outcome: r_outcome, first_day: r_first};
    assign o_entry_count = r_count;

endmodule

FILE: src/sdat_out_reg.sv
// ----------------------------------------------------------------------------
// sdat_out_reg
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module sdat_out_reg import sdat_pkg::*; #(
    parameter int CNT_W = $clog2(DEPTH_DEF + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_result          i_res,
    input  logic [CNT_W-1:0] i_count,
    output logic             o_free,
    sdat_out_if.source       o_out
);

    logic             r_valid;
    t_result          r_res;
    logic [CNT_W-1:0] r_count;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res   <= i_res;
            r_count <= i_count;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.day_seconds = r_res.day_seconds;
    assign o_out.outcome     = r_res.outcome;
    assign o_out.entry_count = r_count;
    assign o_out.first_day   = r_res.first_day;

endmodule

FILE: src/sorted_day_accumulator_table_core.sv
// Lookup and update run a binary search over the n stored entries; an insert
// also shifts the tail above its position p up one slot.
// Throughput: one item at a time; the entry RAM's single read and write port
// bounds both the search (one read a step) and the shift (one slot a cycle).
// Reset: the table empties at once (count and ring head cleared), epoch base 0.
// ----------------------------------------------------------------------------
// sorted_day_accumulator_table_core
// Sorted table of per-day second totals with add and lookup items.
// ----------------------------------------------------------------------------
module sorted_day_accumulator_table_core import sdat_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdat_in_if.sink     i_in,
    sdat_cfg_if.sink    i_cfg,
    sdat_out_if.source  o_out
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [EPOCH_W-1:0] r_epoch_base;
    logic               w_idle;
    logic               w_start;
    logic               w_res_valid;
    logic               w_out_free;
    t_result            w_res;
    logic [CW-1:0]      w_count;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch_base <= '0;
        end else if (i_cfg.valid) begin
            r_epoch_base <= i_cfg.epoch_base;
        end
    end

    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;

    sdat_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_command     (i_in.command),
        .i_epoch_day   (i_in.epoch_day),
        .i_add_seconds (i_in.add_seconds),
        .i_epoch_base  (r_epoch_base),
        .i_out_free    (w_out_free),
        .o_idle        (w_idle),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .o_entry_count (w_count)
    );

    sdat_out_reg #(
        .CNT_W (CW)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_count (w_count),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

endmodule

FILE: src/sdat_checker.sv
// ----------------------------------------------------------------------------
// sdat_checker
// Port-level checks on the sorted day accumulator table, bound to the core.
// ----------------------------------------------------------------------------
module sdat_checker import sdat_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEF,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [SEC_W-1:0]   i_day_seconds,
    input logic [OUTC_W-1:0]  i_outcome,
    input logic [CW-1:0]      i_entry_count,
    input logic [EPOCH_W-1:0] i_first_day
);

    // one item in flight: no new transaction right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transaction");

    a_empty_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_entry_count == '0) |-> (i_first_day == '1))
        else $error("empty table must report first day -1");

    a_zero_secs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_outcome == OC_IGNORED || i_outcome == OC_MISS))
        |-> (i_day_seconds == '0))
        else $error("ignored or missed item reports nonzero seconds");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_outcome == OC_DROPPED)
        |-> (i_entry_count == CW'(TABLE_DEPTH)))
        else $error("oldest entry dropped while table not full");

endmodule

bind sorted_day_accumulator_table_core sdat_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sdat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_day_seconds (o_out.day_seconds),
    .i_outcome     (o_out.outcome),
    .i_entry_count (o_out.entry_count),
    .i_first_day   (o_out.first_day)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add and lookup transactions and epoch base writes into the sorted day
// table, predicts every result from a local copy of the table and checks each
// returned result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import sdat_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CNT_W       = $clog2(DEPTH_DEF + 1);
    localparam int SETTLE      = 8;      // quiet cycles before a base write
    localparam int DRAIN       = 400;    // above the worst insert latency
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYCLES = 2000;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = 32'h7FFF_FFFF;
    localparam logic [EPOCH_W-1:0] EPOCH_MIN = 32'h8000_0000;

    typedef struct {
        bit                 is_base;
        bit                 quiet;
        logic               command;
        logic [EPOCH_W-1:0] epoch_day;
        logic [ADD_W-1:0]   add_seconds;
        logic [EPOCH_W-1:0] epoch_base;
    } t_day_request;

    typedef struct {
        logic [SEC_W-1:0]   day_seconds;
        t_outcome           outcome;
        logic [CNT_W-1:0]   entry_count;
        logic [EPOCH_W-1:0] first_day;
    } t_day_report;

    logic i_clk;
    logic i_rst_n;

    sdat_in_if                   in_if ();
    sdat_cfg_if                  cfg_if ();
    sdat_out_if #(.CNT_W(CNT_W)) out_if ();

    sorted_day_accumulator_table_core #(.TABLE_DEPTH(DEPTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // local copy of the table
    logic [DAY_W-1:0]   shadow_day [DEPTH];
    logic [SEC_W-1:0]   shadow_sec [DEPTH];
    int                 shadow_count;
    logic [EPOCH_W-1:0] shadow_base;

    t_day_request day_requests[$];
    t_day_report  day_reports[$];

    int items_taken;
    bit quiet_mode;
    int gap_left;
    int idle_cycles;
    int stall_left;
    int hold_left;
    bit hold_done;
    int n_fail;

    function automatic bit calm_stretch(int taken);
        return ((taken / 100) % 4) == 3;
    endfunction

    function automatic t_day_report credit_day(logic cmd, logic [EPOCH_W-1:0] ed,
                                               logic [ADD_W-1:0] secs);
        t_day_report      rep;
        longint           rel;
        bit               in_range;
        logic [DAY_W-1:0] day;
        logic [ADD_W:0]   sum;
        int               idx;
        int               pos;
        int               i;
        rel      = longint'($signed(ed)) - longint'($signed(shadow_base));
        in_range = (rel >= 0) && (rel <= 65535);
        day      = in_range ? rel[DAY_W-1:0] : '0;
        idx      = -1;
        rep.day_seconds = '0;
        if (in_range) begin
            for (i = 0; i < shadow_count; i++) begin
                if (idx < 0 && shadow_day[i] == day) idx = i;
            end
        end
        if (cmd == CMD_LOOKUP) begin
            if (idx >= 0) begin
                rep.day_seconds = shadow_sec[idx];
                rep.outcome     = OC_HIT;
            end else begin
                rep.outcome = OC_MISS;
            end
        end else if (!in_range || secs == '0) begin
            rep.outcome = OC_IGNORED;
        end else if (idx >= 0) begin
            sum = {1'b0, secs} + (ADD_W + 1)'(shadow_sec[idx]);
            shadow_sec[idx] = (sum > SEC_MAX) ? SEC_MAX : sum[SEC_W-1:0];
            rep.day_seconds = shadow_sec[idx];
            rep.outcome     = OC_UPDATED;
        end else begin
            rep.outcome = OC_INSERTED;
            if (shadow_count == DEPTH) begin
                // full: oldest day goes first, even if the new day is older
                for (i = 0; i + 1 < DEPTH; i++) begin
                    shadow_day[i] = shadow_day[i+1];
                    shadow_sec[i] = shadow_sec[i+1];
                end
                shadow_count--;
                rep.outcome = OC_DROPPED;
            end
            pos = shadow_count;
            while (pos > 0 && shadow_day[pos-1] > day) begin
                shadow_day[pos] = shadow_day[pos-1];
                shadow_sec[pos] = shadow_sec[pos-1];
                pos--;
            end
            shadow_day[pos] = day;
            shadow_sec[pos] = (secs > SEC_MAX) ? SEC_MAX : secs[SEC_W-1:0];
            rep.day_seconds = shadow_sec[pos];
            shadow_count++;
        end
        rep.entry_count = CNT_W'(shadow_count);
        rep.first_day   = (shadow_count > 0) ? shadow_base + EPOCH_W'(shadow_day[0]) : '1;
        return rep;
    endfunction

    // driver: items and base writes from the request queue
    always @(posedge i_clk) begin
        t_day_request req;
        bit           item_busy;
        bit           base_busy;
        bit           next_item;
        bit           next_base;
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            cfg_if.valid <= 1'b0;
            shadow_count = 0;
            shadow_base  = '0;
            gap_left     = 0;
            idle_cycles  = 0;
        end else begin
            item_busy = in_if.valid && !in_if.ready;
            base_busy = cfg_if.valid && !cfg_if.ready;
            if (in_if.valid && in_if.ready) begin
                day_reports.push_back(credit_day(in_if.command, in_if.epoch_day,
                                                 in_if.add_seconds));
                items_taken <= items_taken + 1;
                if (!quiet_mode && !calm_stretch(items_taken) && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(2, 17);
            end
            if (cfg_if.valid && cfg_if.ready) shadow_base = cfg_if.epoch_base;
            idle_cycles = (day_reports.size() == 0 && !in_if.valid) ? idle_cycles + 1 : 0;

            next_item = item_busy;
            next_base = base_busy;
            if (!item_busy && !base_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (day_requests.size() > 0) begin
                    if (!day_requests[0].is_base) begin
                        req = day_requests.pop_front();
                        in_if.command     <= req.command;
                        in_if.epoch_day   <= req.epoch_day;
                        in_if.add_seconds <= req.add_seconds;
                        next_item = 1'b1;
                    end else if (idle_cycles >= SETTLE) begin
                        req = day_requests.pop_front();
                        cfg_if.epoch_base <= req.epoch_base;
                        next_base = 1'b1;
                        if (req.quiet) quiet_mode <= 1'b1;
                    end
                end
            end
            in_if.valid  <= next_item;
            cfg_if.valid <= next_base;
        end
    end

    // monitor: result checks and receiver stalls
    always @(posedge i_clk) begin
        t_day_report want;
        bit          next_ready;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (day_reports.size() == 0) begin
                    $error("result with no transaction pending");
                    n_fail++;
                end else begin
                    want = day_reports.pop_front();
                    if (out_if.day_seconds !== want.day_seconds) begin
                        $error("day_seconds: expected %0d, actual %0d",
                               want.day_seconds, out_if.day_seconds);
                        n_fail++;
                    end
                    if (out_if.outcome !== want.outcome) begin
                        $error("outcome: expected %0d, actual %0d",
                               want.outcome, out_if.outcome);
                        n_fail++;
                    end
                    if (out_if.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, out_if.entry_count);
                        n_fail++;
                    end
                    if (out_if.first_day !== want.first_day) begin
                        $error("first_day: expected %h, actual %h",
                               want.first_day, out_if.first_day);
                        n_fail++;
                    end
                end
            end
            // one long hold so the block backs up into its input
            if (!hold_done && items_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!quiet_mode && !calm_stretch(items_taken) &&
                         $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 15);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            out_if.ready <= next_ready;
        end
    end

    task automatic queue_item(logic cmd, logic [EPOCH_W-1:0] ed, logic [ADD_W-1:0] secs);
        t_day_request req;
        req.is_base     = 1'b0;
        req.quiet       = 1'b0;
        req.command     = cmd;
        req.epoch_day   = ed;
        req.add_seconds = secs;
        req.epoch_base  = '0;
        day_requests.push_back(req);
    endtask

    task automatic queue_base(logic [EPOCH_W-1:0] base, bit quiet);
        t_day_request req;
        req.is_base     = 1'b1;
        req.quiet       = quiet;
        req.command     = CMD_ADD;
        req.epoch_day   = '0;
        req.add_seconds = '0;
        req.epoch_base  = base;
        day_requests.push_back(req);
    endtask

    // mostly in-range days near the low end and the top of the window,
    // some edge days just outside, some raw noise
    task automatic queue_random(int count, logic [EPOCH_W-1:0] base, bit fill_only);
        int                 r;
        int                 s;
        int                 rel;
        logic               cmd;
        logic [EPOCH_W-1:0] ed;
        logic [ADD_W-1:0]   secs;
        for (int n = 0; n < count; n++) begin
            r = fill_only ? 50 : $urandom_range(0, 99);
            s = $urandom_range(0, 9);
            secs = (s == 0) ? '0 :
                   (s == 1) ? $urandom :
                   (s == 2) ? $urandom_range(60000, 65535) : $urandom_range(1, 2000);
            rel = (!fill_only && $urandom_range(0, 3) == 0) ?
                  65535 - $urandom_range(0, 63) : $urandom_range(0, 1023);
            cmd = (r < 58) ? CMD_ADD : CMD_LOOKUP;
            ed  = base + rel;
            if (r < 10) begin
                cmd  = 1'($urandom_range(0, 1));
                ed   = $urandom;
                secs = $urandom;
            end else begin
                if (r < 14) ed = base + ((r % 2) ? 32'd65536 : 32'hFFFF_FFFF);
                if (cmd == CMD_LOOKUP) secs = $urandom;
            end
            queue_item(cmd, ed, secs);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.command      = CMD_ADD;
        in_if.epoch_day    = '0;
        in_if.add_seconds  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.epoch_base  = '0;
        out_if.ready       = 1'b0;
        items_taken        = 0;
        quiet_mode         = 1'b0;
        n_fail             = 0;

        queue_base(32'd1000, 1'b0);
        queue_item(CMD_LOOKUP, 32'd1000,  32'hFFFF_FFFF);   // empty table
        queue_item(CMD_ADD,    32'd1000,  32'd0);           // zero seconds
        queue_item(CMD_ADD,    32'd999,   32'd5);           // below base
        queue_item(CMD_ADD,    32'd66536, 32'd5);           // past the top day
        queue_item(CMD_ADD,    32'd66535, 32'hFFFF_FFFF);
        queue_item(CMD_ADD,    32'd1000,  32'd1);           // new first entry
        queue_item(CMD_ADD,    32'd1000,  32'h0000_FFFF);   // saturates
        queue_item(CMD_ADD,    32'd1000,  32'd0);           // zero on a present day
        queue_item(CMD_LOOKUP, 32'd1000,  32'd0);
        queue_item(CMD_LOOKUP, 32'd66535, 32'd0);
        queue_item(CMD_LOOKUP, 32'd999,   32'd0);
        queue_item(CMD_LOOKUP, 32'd66536, 32'd0);
        queue_item(CMD_ADD,    EPOCH_MAX, 32'h8000_0000);
        queue_item(CMD_ADD,    EPOCH_MIN, 32'd1);
        queue_item(CMD_ADD,    32'd31000, 32'h0001_2345);   // middle insert
        queue_item(CMD_ADD,    32'd31000, 32'd1);
        queue_item(CMD_ADD,    32'd1100,  32'd7);
        queue_item(CMD_LOOKUP, 32'd1100,  32'h5555_AAAA);

        // wrapped difference would be in range, exact one is not
        queue_base(EPOCH_MAX, 1'b0);
        queue_item(CMD_ADD,    EPOCH_MAX, 32'd9);
        queue_item(CMD_LOOKUP, EPOCH_MAX, 32'd0);
        queue_item(CMD_LOOKUP, EPOCH_MIN, 32'd0);

        queue_base(EPOCH_MIN, 1'b0);
        queue_item(CMD_ADD,    EPOCH_MAX, 32'd3);
        queue_item(CMD_ADD,    EPOCH_MIN + 32'd65535, 32'd2);
        queue_random(300, EPOCH_MIN, 1'b1);
        queue_random(200, EPOCH_MIN, 1'b0);

        queue_base(32'h1234_5678, 1'b0);
        queue_random(450, 32'h1234_5678, 1'b0);

        queue_base(32'hFFFF_FFFF, 1'b0);
        queue_random(250, 32'hFFFF_FFFF, 1'b0);

        queue_base(32'd0, 1'b1);
        queue_random(200, 32'd0, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (day_requests.size() > 0 || in_if.valid || cfg_if.valid ||
               day_reports.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
